>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check an implication on every rising clock edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rbst_pkg.sv
// Types, constants and the divider step for the ray/box slab test.
`timescale 1ns / 1ps
package rbst_pkg;

  localparam int STEP_BITS  = 4;
  localparam int DIV_STAGES = 32 / STEP_BITS;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic CMD_RAY   = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              in_box;
    logic [2:0]        zdir;
    logic [2:0]        zmiss;
    logic signed [31:0] near_t;
    logic signed [31:0] far_t;
  } side_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [31:0] dmag;
    logic [31:0] rem;
    logic [31:0] qd;
  } lane_t;

  function automatic lane_t div_step(lane_t x);
    lane_t      y;
    logic [32:0] tr;
    y = x;
    for (int i = 0; i < STEP_BITS; i++) begin
      tr = {y.rem, y.qd[31]};
      y.qd = {y.qd[30:0], 1'b0};
      if (tr >= {1'b0, y.dmag}) begin
        tr = tr - {1'b0, y.dmag};
        y.qd[0] = 1'b1;
      end
      y.rem = tr[31:0];
    end
    return y;
  endfunction

endpackage

>>> rtl/ray_box_slab_test.sv
// Pipelined ray/box slab intersection and point-in-box test.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block takes one beat per clock and returns one beat per input beat, in order: an input
// stage, a divider setup stage, eight divider stages that each resolve four bits of the 32-bit
// slab quotients for all six planes at once, then saturation, an x/y merge stage and a z merge
// stage that feeds the output register. The user must write the six box registers through the
// cfg port while the pipeline is empty (not enforced). A stall on the master side freezes the
// whole pipeline; s_tready is high whenever the output register is free or taken.
module ray_box_slab_test import rbst_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_near, ray_far
  input  logic [255:0] s_tdata,
  // command
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, t_enter, t_exit, zero pad
  output logic [71:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        REG_BOX_MAX_X: box_max[0] <= cfg_data;
        REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic               p_neg  [6];
  logic [32:0]        p_nmag [6];
  logic [31:0]        p_dmag [6];
  logic [32:0]        c_diff [6];
  logic [31:0]        c_dmag [3];
  side_t              c_side;
  logic               vl_p;
  side_t              sd_p;

  always_comb begin
    c_side.cmd    = s_tuser[0];
    c_side.near_t = s_tdata[223:192];
    c_side.far_t  = s_tdata[255:224];
    c_side.in_box = 1'b1;
    for (int a = 0; a < 3; a++) begin
      org[a] = s_tdata[32*a +: 32];
      dir[a] = s_tdata[96 + 32*a +: 32];
      c_dmag[a] = dir[a][31] ? 32'(33'd0 - {dir[a][31], dir[a]}) : dir[a];
      c_diff[2*a]   = {(dir[a][31] ? box_max[a][31] : box_min[a][31]),
                       (dir[a][31] ? box_max[a] : box_min[a])} - {org[a][31], org[a]};
      c_diff[2*a+1] = {(dir[a][31] ? box_min[a][31] : box_max[a][31]),
                       (dir[a][31] ? box_min[a] : box_max[a])} - {org[a][31], org[a]};
      c_side.zdir[a]  = (dir[a] == '0);
      c_side.zmiss[a] = (dir[a] == '0) && !(org[a] >= box_min[a] && org[a] <= box_max[a]);
      if (!(org[a] > box_min[a] && org[a] < box_max[a])) begin
        c_side.in_box = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_p <= 1'b0;
    end else if (en) begin
      vl_p <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_p <= c_side;
      for (int l = 0; l < 6; l++) begin
        p_neg[l]  <= c_diff[l][32] ^ dir[l/2][31];
        p_nmag[l] <= c_diff[l][32] ? 33'd0 - c_diff[l] : c_diff[l];
        p_dmag[l] <= c_dmag[l/2];
      end
    end
  end

  // divider setup and stages
  logic  vl [DIV_STAGES+1];
  side_t sd [DIV_STAGES+1];
  lane_t ln [DIV_STAGES+1][6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= vl_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sd_p;
      for (int l = 0; l < 6; l++) begin
        ln[0][l].neg  <= p_neg[l];
        ln[0][l].ovf  <= ({15'd0, p_nmag[l][32:16]} >= p_dmag[l]);
        ln[0][l].dmag <= p_dmag[l];
        ln[0][l].rem  <= {15'd0, p_nmag[l][32:16]};
        ln[0][l].qd   <= {p_nmag[l][15:0], 16'd0};
      end
    end
  end

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[st+1] <= 1'b0;
      end else if (en) begin
        vl[st+1] <= vl[st];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[st+1] <= sd[st];
        for (int l = 0; l < 6; l++) begin
          ln[st+1][l] <= div_step(ln[st][l]);
        end
      end
    end
  end

  // saturation
  logic               vl_f1;
  side_t              sd_f1;
  logic signed [31:0] t_lo [3];
  logic signed [31:0] t_hi [3];
  logic signed [31:0] c_sat [6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      if (!ln[DIV_STAGES][l].neg) begin
        c_sat[l] = (ln[DIV_STAGES][l].ovf || ln[DIV_STAGES][l].qd[31]) ? Q_MAX
                                                                      : ln[DIV_STAGES][l].qd;
      end else begin
        c_sat[l] = (ln[DIV_STAGES][l].ovf || ln[DIV_STAGES][l].qd > 32'h8000_0000) ? Q_MIN
                                                     : 32'd0 - ln[DIV_STAGES][l].qd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_f1 <= 1'b0;
    end else if (en) begin
      vl_f1 <= vl[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_f1 <= sd[DIV_STAGES];
      for (int a = 0; a < 3; a++) begin
        t_lo[a] <= sd[DIV_STAGES].zdir[a] ? Q_MIN : c_sat[2*a];
        t_hi[a] <= sd[DIV_STAGES].zdir[a] ? Q_MAX : c_sat[2*a+1];
      end
    end
  end

  // x/y merge
  logic               vl_f2;
  side_t              sd_f2;
  logic               miss2;
  logic signed [31:0] lo2, hi2, z_lo, z_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      vl_f2 <= 1'b0;
    end else if (en) begin
      vl_f2 <= vl_f1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_f2 <= sd_f1;
      miss2 <= (|sd_f1.zmiss) || (t_lo[0] > t_hi[1]) || (t_lo[1] > t_hi[0]);
      lo2   <= (t_lo[1] > t_lo[0]) ? t_lo[1] : t_lo[0];
      hi2   <= (t_hi[1] < t_hi[0]) ? t_hi[1] : t_hi[0];
      z_lo  <= t_lo[2];
      z_hi  <= t_hi[2];
    end
  end

  // z merge, clip and output register
  logic               c_miss, c_hit;
  logic signed [31:0] c_tmin, c_tmax;
  logic               o_hit, o_cmd;
  logic signed [31:0] o_enter, o_exit;

  always_comb begin
    c_miss = miss2 || (lo2 > z_hi) || (z_lo > hi2);
    c_tmin = (z_lo > lo2) ? z_lo : lo2;
    c_tmax = (z_hi < hi2) ? z_hi : hi2;
    c_hit  = !c_miss && (c_tmin <= sd_f2.far_t) && (c_tmax >= sd_f2.near_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vl_f2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_cmd <= sd_f2.cmd;
      if (sd_f2.cmd == CMD_POINT) begin
        o_hit   <= sd_f2.in_box;
        o_enter <= '0;
        o_exit  <= '0;
      end else if (c_hit) begin
        o_hit   <= 1'b1;
        o_enter <= (c_tmin > sd_f2.near_t) ? c_tmin : sd_f2.near_t;
        o_exit  <= (c_tmax < sd_f2.far_t) ? c_tmax : sd_f2.far_t;
      end else begin
        o_hit   <= 1'b0;
        o_enter <= '0;
        o_exit  <= '0;
      end
    end
  end

  assign m_tdata = {7'd0, o_exit, o_enter, o_hit};

  `CHK_IMPL(a_point_zero_t, clk, rst, (m_tvalid && o_cmd == CMD_POINT) |-> (o_enter == '0 && o_exit == '0), "point result carries distances")
  `CHK_IMPL(a_miss_zero_t, clk, rst, (m_tvalid && !o_hit) |-> (o_enter == '0 && o_exit == '0), "miss carries distances")
  `CHK_IMPL(a_empty_ready, clk, rst, !m_tvalid |-> s_tready, "empty output blocks input")
  `CHK_IMPL(a_stall_hold, clk, rst, (m_tvalid && !m_tready) |=> $stable(m_tdata), "stalled result changed")

endmodule
